FILE: rtl/core/afp_pkg.sv
package afp_pkg;

	// Unity gain in the 17-bit gain format with 16 fractional bits.
	localparam logic [16:0] GAIN_ONE = 17'h10000;

	// Signed 24-bit clip limits, held at the 35-bit width of the scaled sample.
	localparam logic signed [34:0] SAMPLE_MAX = 35'sd8388607;
	localparam logic signed [34:0] SAMPLE_MIN = -35'sd8388608;

	// The divider finds the top quotient bit when it starts,
	// then one bit in each step.
	localparam int unsigned DIV_STEPS = 16;
	localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

	// Register indexes, taken from paddr[2].
	localparam logic REG_TRACK_FRAMES = 1'b0;
	localparam logic REG_FADE_FRAMES = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_GAIN,
		ST_MUL_LEFT,
		ST_MUL_RIGHT,
		ST_PACK
	} state_t;

	typedef enum logic [1:0] {
		MUL_GAIN,
		MUL_LEFT,
		MUL_RIGHT
	} mul_sel_t;

	typedef struct packed {
		logic capture;
		logic div_step;
		logic mul_en;
		mul_sel_t mul_sel;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic fade_hit;
		logic div_done;
		logic out_busy;
	} status_t;

endpackage

FILE: rtl/core/afp_ctrl.sv
module afp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  afp_pkg::status_t  status,
	output afp_pkg::cmd_t     cmd
);

	afp_pkg::state_t state_q;
	afp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.mul_sel = afp_pkg::MUL_GAIN;
		case (state_q)
			afp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (status.rem_zero) begin
						state_d = afp_pkg::ST_IDLE;
					end else if (status.fade_hit) begin
						state_d = afp_pkg::ST_DIV;
					end else begin
						state_d = afp_pkg::ST_MUL_LEFT;
					end
				end
			end
			afp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = afp_pkg::ST_GAIN;
				end
			end
			afp_pkg::ST_GAIN: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = afp_pkg::MUL_GAIN;
				state_d = afp_pkg::ST_MUL_LEFT;
			end
			afp_pkg::ST_MUL_LEFT: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = afp_pkg::MUL_LEFT;
				state_d = afp_pkg::ST_MUL_RIGHT;
			end
			afp_pkg::ST_MUL_RIGHT: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = afp_pkg::MUL_RIGHT;
				state_d = afp_pkg::ST_PACK;
			end
			afp_pkg::ST_PACK: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = afp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = afp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/afp_dp.sv
module afp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_remaining,
	input  logic [31:0]         track_frames,
	input  logic [23:0]         fade_frames,
	input  logic signed [31:0]  left_in,
	input  logic signed [31:0]  right_in,
	input  afp_pkg::cmd_t       cmd,
	output afp_pkg::status_t    status,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  left_out,
	output logic signed [15:0]  right_out,
	output logic                last_frame
);

	logic [31:0]        remaining_q;
	logic signed [31:0] left_q;
	logic signed [31:0] right_q;
	logic               last_q;
	logic [23:0]        div_rem_q;
	logic [16:0]        quot_q;
	logic [3:0]         div_cnt_q;
	logic [16:0]        gain_q;
	logic signed [50:0] prod_left_q;
	logic signed [50:0] prod_right_q;
	logic               out_valid_q;
	logic [15:0]        left_out_q;
	logic [15:0]        right_out_q;
	logic               last_out_q;

	logic [23:0]        rem_init;
	logic               quot_top;
	logic [24:0]        div_trial;
	logic [24:0]        div_diff;
	logic               div_ge;
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_p;

	// Scale back by 2^16, clip to signed 24 bits and keep the top 16 of them.
	function automatic logic [15:0] clip_pack(input logic signed [50:0] p);
		logic signed [34:0] s;
		logic [23:0]        c;
		s = signed'(p[50:16]);
		if (s > afp_pkg::SAMPLE_MAX) begin
			c = 24'h7FFFFF;
		end else if (s < afp_pkg::SAMPLE_MIN) begin
			c = 24'h800000;
		end else begin
			c = s[23:0];
		end
		return c[23:8];
	endfunction

	assign status.rem_zero = (remaining_q == 32'd0);
	assign status.fade_hit = (fade_frames != 24'd0) && (remaining_q <= {8'd0, fade_frames});
	assign status.div_done = (div_cnt_q == afp_pkg::DIV_LAST);
	assign status.out_busy = out_valid_q && !out_ready;

	// Inside the fade window r never exceeds fade_frames, so the top quotient
	// bit is set only when the two are equal.
	assign quot_top = (remaining_q[23:0] >= fade_frames);
	assign rem_init = quot_top ? (remaining_q[23:0] - fade_frames) : remaining_q[23:0];

	assign div_trial = {div_rem_q, 1'b0};
	assign div_diff  = div_trial - {1'b0, fade_frames};
	assign div_ge    = (div_trial >= {1'b0, fade_frames});

	always_comb begin
		case (cmd.mul_sel)
			afp_pkg::MUL_GAIN: begin
				mul_a = signed'({16'd0, quot_q});
				mul_b = signed'({1'b0, quot_q});
			end
			afp_pkg::MUL_LEFT: begin
				mul_a = {left_q[31], left_q};
				mul_b = signed'({1'b0, gain_q});
			end
			afp_pkg::MUL_RIGHT: begin
				mul_a = {right_q[31], right_q};
				mul_b = signed'({1'b0, gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 51'(mul_a) * 51'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_remaining) begin
				remaining_q <= track_frames;
			end else if (cmd.capture && !status.rem_zero) begin
				remaining_q <= remaining_q - 32'd1;
			end
			if (cmd.capture) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 4'd1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			left_q <= left_in;
			right_q <= right_in;
			last_q <= (remaining_q == 32'd1);
			gain_q <= afp_pkg::GAIN_ONE;
			quot_q <= {16'd0, quot_top};
			div_rem_q <= rem_init;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[15:0], div_ge};
			div_rem_q <= div_ge ? div_diff[23:0] : div_trial[23:0];
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				afp_pkg::MUL_GAIN: begin
					gain_q <= mul_p[32:16];
				end
				afp_pkg::MUL_LEFT: begin
					prod_left_q <= mul_p;
				end
				afp_pkg::MUL_RIGHT: begin
					prod_right_q <= mul_p;
				end
				default: begin
					gain_q <= gain_q;
				end
			endcase
		end
		if (cmd.load_out) begin
			left_out_q <= clip_pack(prod_left_q);
			right_out_q <= clip_pack(prod_right_q);
			last_out_q <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign left_out   = signed'(left_out_q);
	assign right_out  = signed'(right_out_q);
	assign last_frame = last_out_q;

endmodule

FILE: rtl/core/audio_fade_out_and_pack_unit.sv
// Fade-out and 16-bit packing stage for a stereo audio stream.
// The input channel takes one stereo frame per beat (left_in, right_in, 32-bit signed
// samples); the output channel delivers one packed frame per beat (left_out, right_out
// and last_frame, which marks the final frame of the track).
// Software writes track_frames (address 0) and fade_frames (address 4) over the APB
// port while the stream is idle; writing track_frames reloads the frame counter.
// Within the last fade_frames frames the samples are scaled by a quadratic gain, then
// every sample is clipped to signed 24 bits and its top 16 bits are sent.
// A frame outside the fade window passes through the capture, left multiply, right
// multiply and pack states; a frame inside the window first runs the 16-step
// restoring divider that forms the fade position, then a gain state in which the shared
// multiplier squares it, and that multiplier then scales both channels. A new frame is
// taken as soon as the previous one has moved into the output register, not before.
// Once the counter reaches zero, input frames are consumed and give no output beat.
// After reset both registers are zero, so no output appears until track_frames is
// written. If the receiver stalls, the finished frame waits in the output register
// while the next frame is processed; that frame then waits in turn until the
// register is free.
module audio_fade_out_and_pack_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] left_in,
	input  logic signed [31:0] right_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic               last_frame
);

	logic [31:0] track_frames_q;
	logic [23:0] fade_frames_q;
	logic        reg_write;
	logic        load_remaining;

	afp_pkg::cmd_t    cmd;
	afp_pkg::status_t status;

	// Only address bit 2 picks the register; the byte offset within a word is ignored.
	assign pready = 1'b1;
	assign reg_write = psel && penable && pwrite;
	assign load_remaining = reg_write && (paddr[2] == afp_pkg::REG_TRACK_FRAMES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_frames_q <= '0;
			fade_frames_q <= '0;
		end else if (reg_write) begin
			if (paddr[2] == afp_pkg::REG_TRACK_FRAMES) begin
				track_frames_q <= pwdata;
			end else begin
				fade_frames_q <= pwdata[23:0];
			end
		end
	end

	// Reads return the stored register value.
	always_comb begin
		if (paddr[2] == afp_pkg::REG_TRACK_FRAMES) begin
			prdata = track_frames_q;
		end else begin
			prdata = {8'd0, fade_frames_q};
		end
	end

	afp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	afp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.load_remaining (load_remaining),
		.track_frames   (pwdata),
		.fade_frames    (fade_frames_q),
		.left_in        (left_in),
		.right_in       (right_in),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.left_out       (left_out),
		.right_out      (right_out),
		.last_frame     (last_frame)
	);

endmodule
